FILE: sv/fpc_pkg.sv
// Package for the predictive fan PWM controller: widths, codes, constants
// and the word and status structs shared by all modules.
// No dependencies.
package fpc_pkg;

   // field widths
   localparam int TEMP_W = 11;
   localparam int DUTY_W = 8;
   localparam int RPM_W  = 13;
   localparam int CNT_W  = 32;
   localparam int POL_W  = 3;
   localparam int FUNC_W = 2;
   localparam int CSR_W  = 3;

   // history window
   localparam int HIST_DEPTH = 10;
   localparam int WIN_LEN    = 5;
   localparam int FILL_W     = 4;
   localparam int SUM_W      = 14;

   // signed error datapath, 1/80 degC units
   localparam int ERR_W = 16;

   // duty values
   localparam int DUTY_BASE    = 80;
   localparam int DUTY_FULL    = 255;
   localparam int DUTY_DEFAULT = 128;
   localparam int QUIET_CAP    = 100;

   // minimum tracker start value, 100 degC in 1/16 degC
   localparam int MIN_RESET = 1600;

   // curve breakpoints in 1/80 degC: -5 degC and +10 degC around target
   localparam int CURVE_LO = 400;
   localparam int CURVE_HI = 800;
   // floor(x * 175 / 1200) == (x * CURVE_RECIP) >> CURVE_SHIFT for x < 2048
   localparam int CURVE_X_W   = 11;
   localparam int CURVE_RC_W  = 14;
   localparam int CURVE_RECIP = 9558;
   localparam int CURVE_SHIFT = 16;

   // prediction clamp, 25 degC and 100 degC in 1/80 degC
   localparam int PRED_MIN = 2000;
   localparam int PRED_MAX = 8000;

   // floor(d * 5000 / 255) == (d * RPM_RECIP) >> RPM_SHIFT for d < 256
   localparam int RPM_RC_W  = 21;
   localparam int RPM_RECIP = 1285020;
   localparam int RPM_SHIFT = 16;

   // configuration reset values
   localparam int TARGET_RESET  = 1152;
   localparam int MAX_RESET     = 1360;
   localparam int MIN_DUTY_RST  = 80;
   localparam int MAX_DUTY_RST  = 255;

   typedef logic [TEMP_W-1:0] temp_type;
   typedef logic [DUTY_W-1:0] duty_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [SUM_W-1:0]  sum_type;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_RECORD = 2'd0,
      FUNC_APPLY  = 2'd1,
      FUNC_MANUAL = 2'd2
   } func_type;

   typedef enum logic [POL_W-1:0] {
      POL_PASSIVE    = 3'd0,
      POL_ACTIVE     = 3'd1,
      POL_PREDICTIVE = 3'd2,
      POL_AGGRESSIVE = 3'd3,
      POL_QUIET      = 3'd4
   } policy_type;

   typedef enum logic [CSR_W-1:0] {
      CSR_POLICY   = 3'd0,
      CSR_TARGET   = 3'd1,
      CSR_MAX_TEMP = 3'd2,
      CSR_MIN_DUTY = 3'd3,
      CSR_MAX_DUTY = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      temp_type          temp_sample;
      duty_type          manual_duty;
   } req_type;

   typedef struct packed {
      duty_type          fan_duty;
      logic [RPM_W-1:0]  fan_speed_rpm;
      temp_type          lowest_temp;
      temp_type          highest_temp;
      cnt_type           samples_seen;
      cnt_type           throttle_events;
      logic              over_limit;
   } rsp_type;

   typedef struct packed {
      logic [POL_W-1:0] policy;
      temp_type         set_point;
      temp_type         trip_point;
      duty_type         fan_min_duty;
      duty_type         fan_max_duty;
   } cfg_type;

   // window sums handed from the statistics block to the duty block
   typedef struct packed {
      logic    full;
      sum_type r_sum;
      sum_type o_sum;
   } window_type;

   // statistics after the current word
   typedef struct packed {
      temp_type lowest;
      temp_type highest;
      cnt_type  samples;
      cnt_type  throttles;
   } stats_type;

endpackage

FILE: sv/predictive_fan_pwm_controller.sv
// Path: an accepted word is held in the input register and its result is loaded
// into the result register (input register, then result register).
// Throughput: one word per cycle unless the result side stalls, set by the single pass
// of policy, curve and statistics logic between the input register and the result register.
// Reset: synchronous, active high; restores the configuration defaults,
// clears history, counters and handshake state and sets the duty to 128.
module predictive_fan_pwm_controller
   import fpc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_payload,
   input  logic              csr_we,
   input  logic [CSR_W-1:0]  csr_index,
   input  logic [TEMP_W-1:0] csr_wdata
);

   cfg_type    cfg_ff, cfg_in;
   logic       in_valid;
   req_type    in_data;
   logic       advance;
   logic       over;
   logic       is_record, is_apply;
   logic       flag;
   window_type win;
   stats_type  stats_next;
   duty_type   duty_next;

   // configuration registers, masked to width; unknown indexes drop
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_POLICY:   cfg_in.policy       = csr_wdata[POL_W-1:0];
            CSR_TARGET:   cfg_in.set_point    = csr_wdata[TEMP_W-1:0];
            CSR_MAX_TEMP: cfg_in.trip_point   = csr_wdata[TEMP_W-1:0];
            CSR_MIN_DUTY: cfg_in.fan_min_duty = csr_wdata[DUTY_W-1:0];
            CSR_MAX_DUTY: cfg_in.fan_max_duty = csr_wdata[DUTY_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.policy       <= POL_PREDICTIVE;
         cfg_ff.set_point    <= TEMP_W'(TARGET_RESET);
         cfg_ff.trip_point   <= TEMP_W'(MAX_RESET);
         cfg_ff.fan_min_duty <= DUTY_W'(MIN_DUTY_RST);
         cfg_ff.fan_max_duty <= DUTY_W'(MAX_DUTY_RST);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // move the held word into the result register when there is room
   assign advance = in_valid && (!rsp_valid || rsp_ready);

   assign over      = in_data.temp_sample > cfg_ff.trip_point;
   assign is_record = (in_data.func == FUNC_RECORD);
   assign is_apply  = (in_data.func == FUNC_APPLY);
   assign flag      = over && (is_record || is_apply);

   fpc_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .advance     (advance),
      .in_valid    (in_valid),
      .in_data     (in_data)
   );

   fpc_stats u_stats (
      .clock      (clock),
      .reset      (reset),
      .rec_en     (advance && is_record),
      .temp       (in_data.temp_sample),
      .over       (over),
      .win        (win),
      .stats_next (stats_next)
   );

   fpc_duty u_duty (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .cfg       (cfg_ff),
      .win       (win),
      .item      (in_data),
      .duty_next (duty_next)
   );

   fpc_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .load        (advance),
      .duty        (duty_next),
      .stats       (stats_next),
      .flag        (flag),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

`ifndef SYNTHESIS
   // a held word that cannot move must not be overwritten
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid && !advance) |=> (in_valid && $stable(in_data)))
      else $error("input word lost while stalled");

   // the minimum only falls from its start value
   a_min_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.lowest_temp <= TEMP_W'(MIN_RESET)))
      else $error("lowest temperature above start value");

   // every throttle event is also a recorded sample
   a_thr_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.throttle_events <= rsp_payload.samples_seen))
      else $error("throttle count exceeds sample count");
`endif

endmodule

FILE: sv/fpc_in_stage.sv
// Input register of the fan controller: holds one request word.
// Depends on fpc_pkg.
module fpc_in_stage
   import fpc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   input  logic    advance,
   output logic    in_valid,
   output req_type in_data
);

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff, in_data_in;
   logic    take;

   // accept when empty or when the held word moves on this cycle
   assign req_ready = !in_valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (take) begin
         in_valid_in = 1'b1;
         in_data_in  = req_payload;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_data_ff <= in_data_in;
   end

   assign in_valid = in_valid_ff;
   assign in_data  = in_data_ff;

endmodule

FILE: sv/fpc_stats.sv
// Sample statistics: history shift line with running window sums,
// min/max tracking and saturating sample and throttle counters.
// Depends on fpc_pkg.
module fpc_stats
   import fpc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       rec_en,
   input  temp_type   temp,
   input  logic       over,
   output window_type win,
   output stats_type  stats_next
);

   temp_type             hist_ff [HIST_DEPTH];
   temp_type             hist_in [HIST_DEPTH];
   logic [FILL_W-1:0]    fill_ff, fill_in;
   sum_type              r_sum_ff, r_sum_in;
   sum_type              o_sum_ff, o_sum_in;
   temp_type             min_ff, min_in;
   temp_type             max_ff, max_in;
   cnt_type              samples_ff, samples_in;
   cnt_type              throttle_ff, throttle_in;

   // record: shift the history and slide both window sums
   always_comb begin
      hist_in     = hist_ff;
      fill_in     = fill_ff;
      r_sum_in    = r_sum_ff;
      o_sum_in    = o_sum_ff;
      min_in      = min_ff;
      max_in      = max_ff;
      samples_in  = samples_ff;
      throttle_in = throttle_ff;
      if (rec_en) begin
         hist_in[0] = temp;
         for (int k = 1; k < HIST_DEPTH; k++) begin
            hist_in[k] = hist_ff[k-1];
         end
         r_sum_in = r_sum_ff + SUM_W'(temp) - SUM_W'(hist_ff[WIN_LEN-1]);
         o_sum_in = o_sum_ff + SUM_W'(hist_ff[WIN_LEN-1])
                    - SUM_W'(hist_ff[HIST_DEPTH-1]);
         if (fill_ff != FILL_W'(HIST_DEPTH)) begin
            fill_in = fill_ff + FILL_W'(1);
         end
         if (temp < min_ff) begin
            min_in = temp;
         end
         if (temp > max_ff) begin
            max_in = temp;
         end
         if (samples_ff != '1) begin
            samples_in = samples_ff + CNT_W'(1);
         end
         if (over && (throttle_ff != '1)) begin
            throttle_in = throttle_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < HIST_DEPTH; k++) begin
            hist_ff[k] <= '0;
         end
         fill_ff     <= '0;
         r_sum_ff    <= '0;
         o_sum_ff    <= '0;
         min_ff      <= TEMP_W'(MIN_RESET);
         max_ff      <= '0;
         samples_ff  <= '0;
         throttle_ff <= '0;
      end else begin
         hist_ff     <= hist_in;
         fill_ff     <= fill_in;
         r_sum_ff    <= r_sum_in;
         o_sum_ff    <= o_sum_in;
         min_ff      <= min_in;
         max_ff      <= max_in;
         samples_ff  <= samples_in;
         throttle_ff <= throttle_in;
      end
   end

   assign win.full  = (fill_ff == FILL_W'(HIST_DEPTH));
   assign win.r_sum = r_sum_ff;
   assign win.o_sum = o_sum_ff;

   assign stats_next.lowest    = min_in;
   assign stats_next.highest   = max_in;
   assign stats_next.samples   = samples_in;
   assign stats_next.throttles = throttle_in;

endmodule

FILE: sv/fpc_duty.sv
// Duty selection: policy mux, prediction from the window sums and the
// piecewise-linear fan curve; holds the current duty register.
// Depends on fpc_pkg.
module fpc_duty
   import fpc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  cfg_type    cfg,
   input  window_type win,
   input  req_type    item,
   output duty_type   duty_next
);

   localparam int CURVE_P_W = CURVE_X_W + CURVE_RC_W;

   duty_type                 duty_ff, duty_in;
   logic signed [ERR_W-1:0]  diff, e_act, tgt5, pred, pred_clamp, e_pred, err;
   logic [CURVE_X_W-1:0]     curve_x;
   logic [CURVE_P_W-1:0]     curve_prod;
   duty_type                 curve_duty, pol_duty, quiet_duty;

   // error terms in 1/80 degC: active is five times the 1/16 degC error
   always_comb begin
      diff  = signed'(ERR_W'(item.temp_sample)) - signed'(ERR_W'(cfg.set_point));
      e_act = (diff <<< 2) + diff;
      tgt5  = signed'((ERR_W'(cfg.set_point) << 2) + ERR_W'(cfg.set_point));
      pred  = signed'({1'b0, win.r_sum, 1'b0}) - signed'(ERR_W'(win.o_sum));
      if (pred < PRED_MIN) begin
         pred_clamp = ERR_W'(PRED_MIN);
      end else if (pred > PRED_MAX) begin
         pred_clamp = ERR_W'(PRED_MAX);
      end else begin
         pred_clamp = pred;
      end
      e_pred = pred_clamp - tgt5;
      // short history falls back to the current sample
      if ((cfg.policy == POL_PREDICTIVE) && win.full) begin
         err = e_pred;
      end else begin
         err = e_act;
      end
   end

   // fan curve: flat below the low knee, full above the high knee
   always_comb begin
      curve_x    = CURVE_X_W'(err + ERR_W'(CURVE_LO));
      curve_prod = CURVE_P_W'(curve_x) * CURVE_P_W'(CURVE_RECIP);
      if (err <= -CURVE_LO) begin
         curve_duty = DUTY_W'(DUTY_BASE);
      end else if (err >= CURVE_HI) begin
         curve_duty = DUTY_W'(DUTY_FULL);
      end else begin
         curve_duty = DUTY_W'(DUTY_BASE) + curve_prod[CURVE_SHIFT +: DUTY_W];
      end
   end

   // policy select
   always_comb begin
      quiet_duty = (cfg.fan_min_duty < DUTY_W'(QUIET_CAP)) ?
                   cfg.fan_min_duty : DUTY_W'(QUIET_CAP);
      unique case (cfg.policy)
         POL_PASSIVE:    pol_duty = cfg.fan_min_duty;
         POL_ACTIVE:     pol_duty = curve_duty;
         POL_PREDICTIVE: pol_duty = curve_duty;
         POL_AGGRESSIVE: pol_duty = cfg.fan_max_duty;
         POL_QUIET:      pol_duty = quiet_duty;
         default:        pol_duty = DUTY_W'(DUTY_DEFAULT);
      endcase
   end

   always_comb begin
      unique case (item.func)
         FUNC_APPLY:  duty_in = pol_duty;
         FUNC_MANUAL: duty_in = item.manual_duty;
         default:     duty_in = duty_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff <= DUTY_W'(DUTY_DEFAULT);
      end else if (advance) begin
         duty_ff <= duty_in;
      end
   end

   assign duty_next = duty_in;

endmodule

FILE: sv/fpc_out_stage.sv
// Result register of the fan controller and the duty-to-rpm scaling.
// Depends on fpc_pkg.
module fpc_out_stage
   import fpc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      load,
   input  duty_type  duty,
   input  stats_type stats,
   input  logic      flag,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_payload
);

   localparam int RPM_P_W = DUTY_W + RPM_RC_W;

   logic                 out_valid_ff, out_valid_in;
   duty_type             duty_ff;
   stats_type            stats_ff;
   logic                 flag_ff;
   logic [RPM_P_W-1:0]   rpm_prod;

   // fill on load, drop when taken
   always_comb begin
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (load) begin
         duty_ff  <= duty;
         stats_ff <= stats;
         flag_ff  <= flag;
      end
   end

   // rpm = floor(duty * 5000 / 255) by reciprocal multiply
   assign rpm_prod = RPM_P_W'(duty_ff) * RPM_P_W'(RPM_RECIP);

   assign rsp_valid                   = out_valid_ff;
   assign rsp_payload.fan_duty        = duty_ff;
   assign rsp_payload.fan_speed_rpm   = rpm_prod[RPM_SHIFT +: RPM_W];
   assign rsp_payload.lowest_temp     = stats_ff.lowest;
   assign rsp_payload.highest_temp    = stats_ff.highest;
   assign rsp_payload.samples_seen    = stats_ff.samples;
   assign rsp_payload.throttle_events = stats_ff.throttles;
   assign rsp_payload.over_limit      = flag_ff;

endmodule

FILE: dv/predictive_fan_pwm_controller_test.sv
// Self-checking testbench for the predictive fan PWM controller: drives
// sample, apply and manual words under many register settings and checks
// every result word against a predictor of its own. Depends on fpc_pkg.
`timescale 1ns / 100ps

module predictive_fan_pwm_controller_test;
   import fpc_pkg::*;

   localparam int CLOCK_HALF  = 6;
   localparam int TIMEOUT_NS  = 5_000_000;
   localparam int TEMP_MAX    = 2**TEMP_W - 1;
   localparam int FULL_RPM    = 5000;
   localparam int EDGE_LO     = 80;    // -5 degC in 1/16 degC
   localparam int EDGE_HI     = 160;   // +10 degC in 1/16 degC
   localparam int PHASES      = 16;
   localparam int PHASE_WORDS = 120;
   localparam int HOLD_PHASE  = 3;
   localparam int HOLD_CYCLES = 64;
   localparam int SETTLE      = 4;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam logic [CSR_W-1:0]  CSR_UNUSED  = 3'd7;

   // Predicts the status word of every accepted word and checks results in order.
   class fan_tracker;
      cfg_type     settings;
      temp_type    history [HIST_DEPTH];
      int unsigned fill;
      int unsigned slot;
      cnt_type     samples;
      cnt_type     throttles;
      temp_type    lowest;
      temp_type    highest;
      duty_type    duty;
      rsp_type     status_queue[$];
      int unsigned mismatches;
      int unsigned words_noted;
      int unsigned words_checked;

      function new();
         settings.policy       = POL_PREDICTIVE;
         settings.set_point    = temp_type'(TARGET_RESET);
         settings.trip_point   = temp_type'(MAX_RESET);
         settings.fan_min_duty = duty_type'(MIN_DUTY_RST);
         settings.fan_max_duty = duty_type'(MAX_DUTY_RST);
         foreach (history[k]) history[k] = '0;
         fill          = 0;
         slot          = 0;
         samples       = '0;
         throttles     = '0;
         lowest        = temp_type'(MIN_RESET);
         highest       = '0;
         duty          = duty_type'(DUTY_DEFAULT);
         mismatches    = 0;
         words_noted   = 0;
         words_checked = 0;
      endfunction

      // Mirror a register write; the value is cut to the register's width.
      function void set_reg(logic [CSR_W-1:0] idx, logic [TEMP_W-1:0] data);
         case (idx)
            CSR_POLICY:   settings.policy       = data[POL_W-1:0];
            CSR_TARGET:   settings.set_point    = data;
            CSR_MAX_TEMP: settings.trip_point   = data;
            CSR_MIN_DUTY: settings.fan_min_duty = data[DUTY_W-1:0];
            CSR_MAX_DUTY: settings.fan_max_duty = data[DUTY_W-1:0];
            default: ;
         endcase
      endfunction

      // Duty curve on an error in units of 1/unit degC.
      function duty_type curve_duty(int err, int unit);
         if (err <= -5 * unit)
            return duty_type'(DUTY_BASE);
         if (err >= 10 * unit)
            return duty_type'(DUTY_FULL);
         return duty_type'(DUTY_BASE + (err + 5 * unit) * (DUTY_FULL - DUTY_BASE)
                           / (15 * unit));
      endfunction

      function duty_type predicted_duty(temp_type cur);
         int recent_sum;
         int older_sum;
         int guess;
         recent_sum = 0;
         older_sum  = 0;
         // fall back to the present sample until the window is full
         if (fill < HIST_DEPTH)
            return curve_duty(int'(cur) - int'(settings.set_point), 16);
         for (int k = 1; k <= WIN_LEN; k++) begin
            recent_sum += history[(slot + HIST_DEPTH - k) % HIST_DEPTH];
            older_sum  += history[(slot + HIST_DEPTH - k - WIN_LEN) % HIST_DEPTH];
         end
         // extrapolated temperature in 1/80 degC, held to 25..100 degC
         guess = 2 * recent_sum - older_sum;
         if (guess < PRED_MIN) guess = PRED_MIN;
         if (guess > PRED_MAX) guess = PRED_MAX;
         return curve_duty(guess - 5 * int'(settings.set_point), 80);
      endfunction

      function duty_type policy_duty(temp_type cur);
         case (settings.policy)
            POL_PASSIVE:    return settings.fan_min_duty;
            POL_ACTIVE:     return curve_duty(int'(cur) - int'(settings.set_point), 16);
            POL_PREDICTIVE: return predicted_duty(cur);
            POL_AGGRESSIVE: return settings.fan_max_duty;
            POL_QUIET:      return (settings.fan_min_duty < QUIET_CAP) ?
                                   settings.fan_min_duty : duty_type'(QUIET_CAP);
            default:        return duty_type'(DUTY_DEFAULT);
         endcase
      endfunction

      // Advance the predicted state by one accepted word and queue its status.
      function void note_word(req_type w);
         rsp_type status;
         logic    over;
         over = w.temp_sample > settings.trip_point;
         status.over_limit = 1'b0;
         case (w.func)
            FUNC_RECORD: begin
               if (samples != '1) samples++;
               if (w.temp_sample < lowest)  lowest  = w.temp_sample;
               if (w.temp_sample > highest) highest = w.temp_sample;
               history[slot] = w.temp_sample;
               slot = (slot + 1) % HIST_DEPTH;
               if (fill < HIST_DEPTH) fill++;
               if (over && throttles != '1) throttles++;
               status.over_limit = over;
            end
            FUNC_APPLY: begin
               duty = policy_duty(w.temp_sample);
               status.over_limit = over;
            end
            FUNC_MANUAL: duty = w.manual_duty;
            default: ;
         endcase
         status.fan_duty        = duty;
         status.fan_speed_rpm   = RPM_W'(int'(duty) * FULL_RPM / DUTY_FULL);
         status.lowest_temp     = lowest;
         status.highest_temp    = highest;
         status.samples_seen    = samples;
         status.throttle_events = throttles;
         status_queue.insert(status_queue.size(), status);
         words_noted++;
      endfunction

      function void compare_field(string name, logic [CNT_W-1:0] want,
                                  logic [CNT_W-1:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
         end
      endfunction

      // Match a result word against the oldest pending status.
      function void check_word(rsp_type got);
         rsp_type want;
         if (status_queue.size() == 0) begin
            $error("result word arrived with no status pending");
            mismatches++;
            return;
         end
         want = status_queue.pop_front();
         words_checked++;
         compare_field("fan_duty",        want.fan_duty,        got.fan_duty);
         compare_field("fan_speed_rpm",   want.fan_speed_rpm,   got.fan_speed_rpm);
         compare_field("lowest_temp",     want.lowest_temp,     got.lowest_temp);
         compare_field("highest_temp",    want.highest_temp,    got.highest_temp);
         compare_field("samples_seen",    want.samples_seen,    got.samples_seen);
         compare_field("throttle_events", want.throttle_events, got.throttle_events);
         compare_field("over_limit",      want.over_limit,      got.over_limit);
      endfunction
   endclass

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_ready;
   req_type            req_payload = '0;
   logic               rsp_valid;
   logic               rsp_ready   = 1'b0;
   rsp_type            rsp_payload;
   logic               csr_we      = 1'b0;
   logic [CSR_W-1:0]   csr_index   = '0;
   logic [TEMP_W-1:0]  csr_wdata   = '0;

   fan_tracker tracker = new();
   bit         calm     = 1'b0;
   bit         hold_rsp = 1'b0;
   int         walk_level;

   predictive_fan_pwm_controller i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // Offer one word and hold it until accepted; valid stays high for the caller.
   task automatic send_word(logic [FUNC_W-1:0] func, temp_type temp, duty_type manual);
      req_type w;
      w.func        = func;
      w.temp_sample = temp;
      w.manual_duty = manual;
      req_valid   <= 1'b1;
      req_payload <= w;
      do @(posedge clock); while (!req_ready);
      tracker.note_word(w);
   endtask

   task automatic rest_sender(int unsigned cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Drop valid and wait until every pending status has been matched.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.status_queue.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_W-1:0] idx, logic [TEMP_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      tracker.set_reg(idx, data);
   endtask

   // Write every register, with junk above the width of the policy and duty registers, then an unused index.
   task automatic load_settings(cfg_type c);
      write_reg(CSR_POLICY,   {8'($urandom()), c.policy});
      write_reg(CSR_TARGET,   c.set_point);
      write_reg(CSR_MAX_TEMP, c.trip_point);
      write_reg(CSR_MIN_DUTY, {3'($urandom()), c.fan_min_duty});
      write_reg(CSR_MAX_DUTY, {3'($urandom()), c.fan_max_duty});
      write_reg(CSR_UNUSED,   temp_type'($urandom()));
      csr_we <= 1'b0;
   endtask

   function automatic logic [FUNC_W-1:0] pick_func();
      int unsigned roll;
      roll = $urandom_range(0, 19);
      if (roll < 11) return FUNC_RECORD;
      if (roll < 17) return FUNC_APPLY;
      if (roll < 19) return FUNC_MANUAL;
      return FUNC_UNUSED;
   endfunction

   // Mostly a slow walk around the target, some uniform noise, some curve edges.
   function automatic temp_type pick_temp(int target, int limit);
      int unsigned roll;
      int t;
      roll = $urandom_range(0, 9);
      if (roll < 6) begin
         walk_level += int'($urandom_range(0, 48)) - 24;
         walk_level += (target - walk_level) / 32;
         if (walk_level < 0) walk_level = 0;
         if (walk_level > TEMP_MAX) walk_level = TEMP_MAX;
         t = walk_level;
      end else if (roll < 8) begin
         t = $urandom_range(0, TEMP_MAX);
      end else begin
         case ($urandom_range(0, 7))
            0: t = 0;
            1: t = TEMP_MAX;
            2: t = target - EDGE_LO;
            3: t = target - EDGE_LO + 1;
            4: t = target + EDGE_HI;
            5: t = target + EDGE_HI - 1;
            6: t = limit;
            default: t = limit + 1;
         endcase
      end
      if (t < 0) t = 0;
      if (t > TEMP_MAX) t = TEMP_MAX;
      return temp_type'(t);
   endfunction

   // Result side: random stalls, one long hold-off on request, none when calm.
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_word(rsp_payload);
   end

   initial begin
      #TIMEOUT_NS;
      $display("timeout with %0d status words pending", tracker.status_queue.size());
      $display("predictive_fan_pwm_controller_test: FAIL");
      $finish;
   end

   initial begin
      cfg_type     phase_cfg;
      int unsigned phase;
      int unsigned n;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: short-history apply, minimum start value, field extremes,
      // unused func, full window with clamp high and clamp low.
      send_word(FUNC_APPLY,  temp_type'(TEMP_MAX), '0);
      send_word(FUNC_RECORD, temp_type'(MIN_RESET + 100), '1);
      send_word(FUNC_RECORD, temp_type'(MIN_RESET), '0);
      send_word(FUNC_RECORD, temp_type'(TEMP_MAX), '0);
      send_word(FUNC_RECORD, '0, '1);
      send_word(FUNC_UNUSED, temp_type'(TEMP_MAX), '1);
      send_word(FUNC_MANUAL, '0, '0);
      send_word(FUNC_MANUAL, temp_type'(TEMP_MAX), '1);
      repeat (6) send_word(FUNC_RECORD, temp_type'(TEMP_MAX), '0);
      send_word(FUNC_APPLY, '0, '0);
      repeat (5) send_word(FUNC_RECORD, '0, '1);
      send_word(FUNC_APPLY, temp_type'(TEMP_MAX), '1);
      drain_results();

      // Random phases, each under its own register setting.
      for (phase = 0; phase < PHASES; phase++) begin
         if (phase == 0) begin
            phase_cfg = '{policy: POL_ACTIVE, set_point: '0, trip_point: '0,
                          fan_min_duty: '0, fan_max_duty: '0};
         end else if (phase == 1) begin
            phase_cfg = '{policy: POL_ACTIVE, set_point: '1, trip_point: '1,
                          fan_min_duty: '1, fan_max_duty: '1};
         end else begin
            phase_cfg.policy       = POL_W'(phase % 8);
            phase_cfg.set_point    = temp_type'($urandom_range(160, 1900));
            phase_cfg.trip_point   = $urandom_range(0, 1) ?
                                     temp_type'(phase_cfg.set_point + $urandom_range(0, 140)) :
                                     temp_type'($urandom());
            phase_cfg.fan_min_duty = (phase % 8 == POL_QUIET && phase > 8) ?
                                     duty_type'($urandom_range(0, QUIET_CAP - 1)) :
                                     duty_type'($urandom());
            phase_cfg.fan_max_duty = duty_type'($urandom());
         end
         load_settings(phase_cfg);
         walk_level = phase_cfg.set_point;
         calm = (phase >= PHASES - 2);
         if (phase == HOLD_PHASE)
            hold_rsp = 1'b1;
         for (n = 0; n < PHASE_WORDS; n++) begin
            send_word(pick_func(),
                      pick_temp(phase_cfg.set_point, phase_cfg.trip_point),
                      duty_type'($urandom()));
            if (!calm && $urandom_range(0, 3) == 0)
               rest_sender($urandom_range(1, 5));
         end
         drain_results();
      end

      repeat (8) @(posedge clock);
      if (tracker.status_queue.size() != 0) begin
         $error("%0d status words never arrived", tracker.status_queue.size());
         tracker.mismatches++;
      end
      $display("Sent %0d words under %0d register settings (all policy and func codes);",
               tracker.words_noted, PHASES + 1);
      $display("checked %0d result words, %0d mismatches.",
               tracker.words_checked, tracker.mismatches);
      if (tracker.mismatches == 0)
         $display("predictive_fan_pwm_controller_test: PASS");
      else
         $display("predictive_fan_pwm_controller_test: FAIL");
      $finish;
   end

endmodule
